// ===== src/tga_pkg.sv =====
package tga_pkg;

  // Default sizes of the two stores.
  localparam int MAX_POINTS_DEF = 1024;
  localparam int MAX_DIMS_DEF   = 4;

  // Field and datapath widths.
  localparam int COORD_W    = 32;
  localparam int GRAD_W     = 48;
  localparam int WEIGHT_W   = 24;
  localparam int CONST_W    = 15;
  localparam int OFFSET_W   = 14;
  localparam int PROD_W     = WEIGHT_W + CONST_W;
  localparam int FRAC_SHIFT = 58;
  localparam int NUM_W      = PROD_W + FRAC_SHIFT;
  localparam int T_W        = 54;
  localparam int MAG_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int DIMS_W     = 3;
  localparam int PTS_W      = 11;

  // Input item kinds.
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_PAIR  = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  // Pair types.
  typedef enum logic [1:0] {
    PT_NEIGHBOR = 2'd0,
    PT_MIDNEAR  = 2'd1,
    PT_FURTHER  = 2'd2,
    PT_NONE     = 2'd3
  } pair_type_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_SAT   = 2'd2
  } status_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_W_NEIGHBOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_W_MIDNEAR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_W_FURTHER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS     = 3'd4;

  // Register reset values.
  localparam logic [WEIGHT_W-1:0] RST_W_NEIGHBOR = 24'd32768;
  localparam logic [WEIGHT_W-1:0] RST_W_MIDNEAR  = 24'd16384000;
  localparam logic [WEIGHT_W-1:0] RST_W_FURTHER  = 24'd16384;
  localparam logic [DIMS_W-1:0]   RST_DIMS       = 3'd2;
  localparam logic [PTS_W-1:0]    RST_POINTS     = 11'd1024;

  // Numerator constants and distance offsets of each pair type.
  localparam logic [CONST_W-1:0]  C_NEIGHBOR = 15'd20;
  localparam logic [CONST_W-1:0]  C_MIDNEAR  = 15'd20000;
  localparam logic [CONST_W-1:0]  C_FURTHER  = 15'd2;
  localparam logic [OFFSET_W-1:0] K_NEIGHBOR = 14'd10;
  localparam logic [OFFSET_W-1:0] K_MIDNEAR  = 14'd10000;
  localparam logic [OFFSET_W-1:0] K_FURTHER  = 14'd1;

  localparam logic signed [GRAD_W-1:0] GRAD_MAX = {1'b0, {(GRAD_W-1){1'b1}}};
  localparam logic signed [GRAD_W-1:0] GRAD_MIN = {1'b1, {(GRAD_W-1){1'b0}}};

  // Sequencer states.
  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_WAIT,
    S_CHECK,
    S_SUM_RD,
    S_SUM_DIFF,
    S_SUM_SQ,
    S_SUM_ACC,
    S_T,
    S_DIV1_GO,
    S_DIV1,
    S_DIV2_GO,
    S_DIV2,
    S_UPD_RD,
    S_UPD_DIFF,
    S_MUL_LO,
    S_MUL_HI,
    S_COMP,
    S_UPD_A,
    S_RD_B,
    S_UPD_B,
    S_DONE
  } tga_state_t;

endpackage

// ===== src/tga_divider.sv =====
module tga_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [tga_pkg::NUM_W-1:0] num,
  input  logic [tga_pkg::T_W-1:0]   den,
  output logic                      done,
  output logic [tga_pkg::NUM_W-1:0] quo
);
  import tga_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             run_r;
  logic [CNT_W-1:0] cnt_r;
  logic [T_W:0]     rem_r;
  logic [T_W-1:0]   den_r;
  logic [NUM_W-1:0] quo_r;
  logic [T_W:0]     shifted;
  logic             fits;

  // One restoring step: bring down the next numerator bit and try to subtract.
  assign shifted = {rem_r[T_W-1:0], quo_r[NUM_W-1]};
  assign fits    = (shifted >= {1'b0, den_r});
  assign done    = run_r && (cnt_r == CNT_W'(NUM_W - 1));
  assign quo     = quo_r;

  // Step control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (done) begin
        run_r <= 1'b0;
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (run_r) begin
      rem_r <= fits ? (shifted - {1'b0, den_r}) : shifted;
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
  end

endmodule

// ===== src/triplet_gradient_accumulator_core.sv =====
// Triplet gradient accumulator.
// Input channel: an item is taken when start is high and busy is low. Kinds are
// coordinate write, gradient clear, pair update and gradient read.
// Result channel: every item gives one transaction on out_read_value and
// out_status, marked by a one-cycle out_valid pulse. The receiver cannot stall.
// Configuration: cfg_we writes cfg_wdata to register cfg_index at once.
// Answers: a write or an out-of-range read answers in the next cycle and
// leaves busy low; a valid read answers through the RD_WAIT state and the
// result register. A pair that is out of range or has no effect answers from
// the CHECK state through the result register. A full pair's answer waits on
// the bit-serial divider, which runs twice (once per factor of the squared
// denominator), and on the gradient store with its one read port, whose anchor
// and partner entries are read, modified and written in turn.
// Clear: the gradient store is swept one entry per cycle over all
// MAX_POINTS*MAX_DIMS entries (4096 by default). The same sweep runs after reset,
// with busy high and no result; configuration writes are taken throughout.
module triplet_gradient_accumulator_core #(
  parameter int MAX_POINTS = tga_pkg::MAX_POINTS_DEF,
  parameter int MAX_DIMS   = tga_pkg::MAX_DIMS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            in_kind,
  input  logic [9:0]                            in_point_index,
  input  logic [9:0]                            in_other_index,
  input  logic [1:0]                            in_dim_index,
  input  logic [1:0]                            in_pair_type,
  input  logic signed [tga_pkg::COORD_W-1:0]    in_coord_value,
  output logic                                  out_valid,
  output logic signed [tga_pkg::GRAD_W-1:0]     out_read_value,
  output logic [1:0]                            out_status,
  input  logic                                  cfg_we,
  input  logic [tga_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tga_pkg::WEIGHT_W-1:0]          cfg_wdata
);
  import tga_pkg::*;

  localparam int DEPTH = MAX_POINTS * MAX_DIMS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DJ_W  = $clog2(MAX_DIMS + 1);

  tga_state_t state_r, state_nxt;

  // Configuration registers.
  logic [WEIGHT_W-1:0] wn_r, wm_r, wf_r;
  logic [DIMS_W-1:0]   dims_r;
  logic [PTS_W-1:0]    pts_r;

  // Item and loop registers.
  logic [9:0]           pi_r, oi_r;
  logic [1:0]           pt_r;
  logic [DJ_W-1:0]      j_r, nd_r;
  logic [AW-1:0]        clr_cnt_r;
  logic                 clr_item_r;
  logic                 sat_r;
  logic [PROD_W-1:0]    c_r;
  logic [T_W-1:0]       sum_r, t_r;
  logic [COORD_W-1:0]   ad_r;
  logic                 neg_df_r;
  logic [63:0]          sq_r, p0_r, p1_r;
  logic signed [GRAD_W-1:0] comp_r;

  // Result registers.
  logic                     out_valid_r;
  logic signed [GRAD_W-1:0] out_value_r;
  logic [1:0]               out_status_r;

  // Memories and their ports.
  logic [COORD_W-1:0]       emb_mem [DEPTH];
  logic signed [GRAD_W-1:0] grad_mem [DEPTH];
  logic [COORD_W-1:0]       e_rd_a_r, e_rd_b_r;
  logic signed [GRAD_W-1:0] g_rd_r;
  logic                     e_we, e_re, g_we, g_re;
  logic [AW-1:0]            g_waddr, g_raddr;
  logic signed [GRAD_W-1:0] g_wdata;

  // Result strobes for the output registers.
  logic                     res_valid;
  logic signed [GRAD_W-1:0] res_value;
  logic [1:0]               res_status;

  // Divider link.
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [MAG_W-1:0] mag;

  // Decoded values.
  logic             accept, in_ok;
  logic [AW-1:0]    addr_in, addr_a, addr_b;
  logic [31:0]      np;
  logic             pair_oor;
  logic [DJ_W-1:0]  nd_c;
  logic             last_dim;
  logic             clr_last;
  logic [COORD_W:0] df_c;
  logic [COORD_W-1:0] ad_c;
  logic [64:0]      pp_c;
  logic             cm_sat;
  logic [GRAD_W-1:0] cm_c;
  logic             comp_neg;
  logic signed [GRAD_W:0] upd_c;
  logic             upd_hi, upd_lo;
  logic signed [GRAD_W-1:0] upd_sat;
  logic [WEIGHT_W-1:0] w_sel;
  logic [CONST_W-1:0]  c_sel;
  logic [OFFSET_W-1:0] k_sel;

  assign accept   = start && !busy;
  assign busy     = (state_r != S_IDLE);
  assign in_ok    = (32'(in_point_index) < MAX_POINTS) && (32'(in_dim_index) < MAX_DIMS);
  assign addr_in  = AW'(32'(in_point_index) * MAX_DIMS + 32'(in_dim_index));
  assign addr_a   = AW'(32'(pi_r) * MAX_DIMS + 32'(j_r));
  assign addr_b   = AW'(32'(oi_r) * MAX_DIMS + 32'(j_r));
  assign np       = (32'(pts_r) > MAX_POINTS) ? MAX_POINTS : 32'(pts_r);
  assign pair_oor = (32'(pi_r) >= np) || (32'(oi_r) >= np);
  assign last_dim = ((j_r + 1'b1) >= nd_r);
  assign clr_last = (clr_cnt_r == AW'(DEPTH - 1));
  assign mag      = div_quo[MAG_W-1:0];

  // Dimension count clamped to the store's range.
  always_comb begin
    if (dims_r == '0) begin
      nd_c = DJ_W'(1);
    end else if (32'(dims_r) > MAX_DIMS) begin
      nd_c = DJ_W'(MAX_DIMS);
    end else begin
      nd_c = DJ_W'(dims_r);
    end
  end

  // Weight, constant and offset of the pair type.
  always_comb begin
    case (pt_r)
      PT_NEIGHBOR: begin
        w_sel = wn_r;
        c_sel = C_NEIGHBOR;
        k_sel = K_NEIGHBOR;
      end
      PT_MIDNEAR: begin
        w_sel = wm_r;
        c_sel = C_MIDNEAR;
        k_sel = K_MIDNEAR;
      end
      default: begin
        w_sel = wf_r;
        c_sel = C_FURTHER;
        k_sel = K_FURTHER;
      end
    endcase
  end

  // Coordinate difference and its magnitude.
  assign df_c = {e_rd_a_r[COORD_W-1], e_rd_a_r} - {e_rd_b_r[COORD_W-1], e_rd_b_r};
  assign ad_c = df_c[COORD_W] ? COORD_W'(-df_c) : df_c[COORD_W-1:0];

  // Component magnitude in Q.24, saturated, and its sign.
  assign pp_c     = {1'b0, p1_r} + 65'(p0_r[63:32]);
  assign cm_sat   = (pp_c > 65'(GRAD_MAX));
  assign cm_c     = cm_sat ? GRAD_MAX : pp_c[GRAD_W-1:0];
  assign comp_neg = (pt_r == PT_FURTHER) != neg_df_r;

  // Gradient update with saturation; anchor adds, partner subtracts.
  assign upd_c   = (state_r == S_UPD_A) ?
                   ({g_rd_r[GRAD_W-1], g_rd_r} + {comp_r[GRAD_W-1], comp_r}) :
                   ({g_rd_r[GRAD_W-1], g_rd_r} - {comp_r[GRAD_W-1], comp_r});
  assign upd_hi  = !upd_c[GRAD_W] && upd_c[GRAD_W-1];
  assign upd_lo  = upd_c[GRAD_W] && !upd_c[GRAD_W-1];
  assign upd_sat = upd_hi ? GRAD_MAX : (upd_lo ? GRAD_MIN : upd_c[GRAD_W-1:0]);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:    if (clr_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_CLEAR: state_nxt = S_CLEAR;
            KIND_PAIR:  state_nxt = S_CHECK;
            KIND_READ:  state_nxt = in_ok ? S_RD_WAIT : S_IDLE;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD_WAIT:  state_nxt = S_IDLE;
      S_CHECK:    state_nxt = (pair_oor || pt_r == PT_NONE) ? S_IDLE : S_SUM_RD;
      S_SUM_RD:   state_nxt = S_SUM_DIFF;
      S_SUM_DIFF: state_nxt = S_SUM_SQ;
      S_SUM_SQ:   state_nxt = S_SUM_ACC;
      S_SUM_ACC:  state_nxt = last_dim ? S_T : S_SUM_RD;
      S_T:        state_nxt = S_DIV1_GO;
      S_DIV1_GO:  state_nxt = S_DIV1;
      S_DIV1:     if (div_done) state_nxt = S_DIV2_GO;
      S_DIV2_GO:  state_nxt = S_DIV2;
      S_DIV2:     if (div_done) state_nxt = S_UPD_RD;
      S_UPD_RD:   state_nxt = S_UPD_DIFF;
      S_UPD_DIFF: state_nxt = S_MUL_LO;
      S_MUL_LO:   state_nxt = S_MUL_HI;
      S_MUL_HI:   state_nxt = S_COMP;
      S_COMP:     state_nxt = S_UPD_A;
      S_UPD_A:    state_nxt = S_RD_B;
      S_RD_B:     state_nxt = S_UPD_B;
      S_UPD_B:    state_nxt = last_dim ? S_DONE : S_UPD_RD;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Memory strobes, divider start and result of each state.
  always_comb begin
    e_we       = 1'b0;
    e_re       = 1'b0;
    g_we       = 1'b0;
    g_re       = 1'b0;
    g_waddr    = addr_a;
    g_raddr    = addr_a;
    g_wdata    = upd_sat;
    div_start  = 1'b0;
    div_num    = div_quo;
    res_valid  = 1'b0;
    res_value  = '0;
    res_status = STAT_OK;
    case (state_r)
      S_CLEAR: begin
        g_we    = 1'b1;
        g_waddr = clr_cnt_r;
        g_wdata = '0;
        res_valid = clr_last && clr_item_r;
      end
      S_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_WRITE: begin
              e_we       = in_ok;
              res_valid  = 1'b1;
              res_status = in_ok ? STAT_OK : STAT_RANGE;
            end
            KIND_READ: begin
              g_re       = in_ok;
              g_raddr    = addr_in;
              res_valid  = !in_ok;
              res_status = STAT_RANGE;
            end
            default: ;
          endcase
        end
      end
      S_RD_WAIT: begin
        res_valid = 1'b1;
        res_value = g_rd_r;
      end
      S_CHECK: begin
        res_valid  = pair_oor || (pt_r == PT_NONE);
        res_status = pair_oor ? STAT_RANGE : STAT_OK;
      end
      S_SUM_RD, S_UPD_RD: e_re = 1'b1;
      S_UPD_DIFF: g_re = 1'b1;
      S_DIV1_GO: begin
        div_start = 1'b1;
        div_num   = {c_r, {FRAC_SHIFT{1'b0}}};
      end
      S_DIV2_GO: div_start = 1'b1;
      S_UPD_A: g_we = 1'b1;
      S_RD_B: begin
        g_re    = 1'b1;
        g_raddr = addr_b;
      end
      S_UPD_B: begin
        g_we    = 1'b1;
        g_waddr = addr_b;
      end
      S_DONE: begin
        res_valid  = 1'b1;
        res_status = sat_r ? STAT_SAT : STAT_OK;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      clr_item_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= res_valid;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_last ? '0 : clr_cnt_r + 1'b1;
      end
      if (accept && in_kind == KIND_CLEAR) begin
        clr_item_r <= 1'b1;
      end else if (state_r == S_CLEAR && clr_last) begin
        clr_item_r <= 1'b0;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wn_r   <= RST_W_NEIGHBOR;
      wm_r   <= RST_W_MIDNEAR;
      wf_r   <= RST_W_FURTHER;
      dims_r <= RST_DIMS;
      pts_r  <= RST_POINTS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_W_NEIGHBOR: wn_r   <= cfg_wdata;
        CFG_W_MIDNEAR:  wm_r   <= cfg_wdata;
        CFG_W_FURTHER:  wf_r   <= cfg_wdata;
        CFG_DIMS:       dims_r <= cfg_wdata[DIMS_W-1:0];
        CFG_POINTS:     pts_r  <= cfg_wdata[PTS_W-1:0];
        default: ;
      endcase
    end
  end

  // Result registers, item capture and pair datapath.
  always_ff @(posedge clk) begin
    out_value_r  <= res_value;
    out_status_r <= res_status;
    if (accept) begin
      pi_r <= in_point_index;
      oi_r <= in_other_index;
      pt_r <= in_pair_type;
    end
    case (state_r)
      S_CHECK: begin
        c_r   <= PROD_W'(w_sel * c_sel);
        nd_r  <= nd_c;
        j_r   <= '0;
        sum_r <= '0;
        sat_r <= 1'b0;
      end
      S_SUM_DIFF, S_UPD_DIFF: begin
        ad_r     <= ad_c;
        neg_df_r <= df_c[COORD_W];
      end
      S_SUM_SQ: sq_r <= ad_r * ad_r;
      S_SUM_ACC: begin
        sum_r <= sum_r + T_W'(sq_r[63:16]);
        j_r   <= j_r + 1'b1;
      end
      S_T: begin
        t_r <= T_W'({k_sel, 16'b0}) + T_W'(32'h10000) + sum_r;
        j_r <= '0;
      end
      S_MUL_LO: p0_r <= mag[31:0] * ad_r;
      S_MUL_HI: p1_r <= mag[63:32] * ad_r;
      S_COMP: begin
        comp_r <= comp_neg ? -$signed(cm_c) : $signed(cm_c);
        if (cm_sat) sat_r <= 1'b1;
      end
      S_UPD_A: if (upd_hi || upd_lo) sat_r <= 1'b1;
      S_UPD_B: begin
        if (upd_hi || upd_lo) sat_r <= 1'b1;
        j_r <= j_r + 1'b1;
      end
      default: ;
    endcase
  end

  // Embedding store: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (e_we) begin
      emb_mem[addr_in] <= in_coord_value;
    end
    if (e_re) begin
      e_rd_a_r <= emb_mem[addr_a];
      e_rd_b_r <= emb_mem[addr_b];
    end
  end

  // Gradient store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (g_we) begin
      grad_mem[g_waddr] <= g_wdata;
    end
    if (g_re) begin
      g_rd_r <= grad_mem[g_raddr];
    end
  end

  // Shared divider for both factors of the squared denominator.
  tga_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (t_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_status     = out_status_r;

endmodule

// ===== src/tga_checker.sv =====
module tga_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic [1:0]                         in_kind,
  input logic                               out_valid,
  input logic signed [tga_pkg::GRAD_W-1:0]  out_read_value,
  input logic [1:0]                         out_status
);
  import tga_pkg::*;

  // A write transaction is answered in the very next cycle with a zero value.
  a_write_answer: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_kind == KIND_WRITE |=> out_valid && out_read_value == '0)
    else $error("write transaction not answered in the next cycle");

  // A read either answers at once (out of range) or goes busy, never both.
  a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_kind == KIND_READ |=> (busy != out_valid))
    else $error("read transaction took neither path");

  // A clear or a pair always keeps the block busy afterwards.
  a_long_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_kind == KIND_CLEAR || in_kind == KIND_PAIR) |=> busy && !out_valid)
    else $error("long transaction did not hold busy");

  // No result leaves during or straight after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  // Status never takes the unused code.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK || out_status == STAT_RANGE || out_status == STAT_SAT))
    else $error("unused status code");

endmodule

bind triplet_gradient_accumulator_core tga_checker u_tga_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_kind        (in_kind),
  .out_valid      (out_valid),
  .out_read_value (out_read_value),
  .out_status     (out_status)
);
